/* hw/rtl/dtc_pkg.sv */
// Shared types, constants and a helper function for the dual timer/counter block.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int TimerCountDefault = 2;

    localparam int DataWidth = 32;
    localparam int CsWidth   = 11;
    localparam int AddrWidth = 3;

    // Item kinds carried on the action field. The fourth code has no meaning.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Register select codes, word_addr bits 1:0.
    localparam logic [1:0] REG_CTRL  = 2'd0;
    localparam logic [1:0] REG_LOAD  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Bit positions inside the control/status word.
    localparam int CS_UDT  = 1;
    localparam int CS_ARHT = 4;
    localparam int CS_ENIT = 6;
    localparam int CS_ENT  = 7;
    localparam int CS_TINT = 8;

    // Per-timer command for the item being processed this cycle.
    typedef struct packed {
        logic                 tick;
        logic                 write;
        logic [1:0]           reg_sel;
        logic [DataWidth-1:0] wdata;
    } dtc_cmd_t;

    // Reload value: the load value when counting down, its complement otherwise.
    function automatic logic [DataWidth-1:0] dtc_period(
        input logic                 down_mode,
        input logic [DataWidth-1:0] load
    );
        return down_mode ? load : ~load;
    endfunction

endpackage

/* hw/rtl/dtc_timer.sv */
// One timer channel: control/status, load, spare and counter registers.
// Depends on dtc_pkg for the command struct, bit positions and period function.
`timescale 1ns / 1ps

module dtc_timer
    import dtc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 present,
    input  dtc_cmd_t             cmd,
    output logic [DataWidth-1:0] rdata,
    output logic                 irq_next
);

    logic [CsWidth-1:0]   cs_reg,      cs_next;
    logic [DataWidth-1:0] load_reg,    load_next;
    logic [DataWidth-1:0] spare_reg,   spare_next;
    logic [DataWidth-1:0] cnt_reg,     cnt_next;
    logic                 running_reg, running_next;
    logic [DataWidth-1:0] cnt_dec;

    always_comb
    begin
        cs_next      = cs_reg;
        load_next    = load_reg;
        spare_next   = spare_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        cnt_dec      = (cnt_reg != '0) ? cnt_reg - DataWidth'(1) : '0;

        if (cmd.tick && running_reg)
        begin
            if (cnt_dec == '0)
            begin
                cs_next[CS_TINT] = 1'b1;
                if (cs_reg[CS_ARHT])
                begin
                    cnt_next = dtc_period(cs_reg[CS_UDT], load_reg);
                end
                else
                begin
                    cnt_next     = '0;
                    running_next = 1'b0;
                end
            end
            else
            begin
                cnt_next = cnt_dec;
            end
        end

        if (cmd.write)
        begin
            case (cmd.reg_sel)
                REG_CTRL:
                begin
                    cs_next          = cmd.wdata[CsWidth-1:0];
                    cs_next[CS_TINT] = 1'b0;
                    if (cmd.wdata[CS_ENT])
                    begin
                        cnt_next     = dtc_period(cmd.wdata[CS_UDT], load_reg);
                        running_next = 1'b1;
                    end
                end
                REG_LOAD:  load_next  = cmd.wdata;
                REG_SPARE: spare_next = cmd.wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg      <= '0;
            load_reg    <= '0;
            spare_reg   <= '0;
            cnt_reg     <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            cs_reg      <= cs_next;
            load_reg    <= load_next;
            spare_reg   <= spare_next;
            cnt_reg     <= cnt_next;
            running_reg <= running_next;
        end
    end

    // Readback uses the current state; a read never changes it.
    always_comb
    begin
        case (cmd.reg_sel)
            REG_CTRL:  rdata = DataWidth'(cs_reg);
            REG_LOAD:  rdata = load_reg;
            REG_COUNT: rdata = cs_reg[CS_UDT] ? cnt_reg : ~cnt_reg;
            default:   rdata = spare_reg;
        endcase
    end

    assign irq_next = present & cs_next[CS_TINT] & cs_next[CS_ENIT];

endmodule

/* hw/rtl/dual_timer_counter_regs.sv */
// Top level of the dual 32-bit timer/counter with auto-reload and its registers.
// Depends on dtc_pkg and instantiates dtc_timer once per timer.
`timescale 1ns / 1ps

// Each item is a tick, a register read or a register write and yields exactly
// one result carrying read_data (zero unless it was a read of a present timer)
// and the shared irq level after the item. An item waits in the input
// register, where the timers' next state is worked out and committed, and
// then sits in the output register until taken; with out_ready held high
// the block takes one item every clock. The output register is the only
// thing that stalls the pipe; while it holds an untaken result the input
// register can still fill, so in_ready drops only when both are full.
// word_addr bit 2 selects the timer and bits 1:0 the register (control,
// load, counter, spare). A control write clears the interrupt flag and,
// with the enable bit set, loads the period and starts the counter;
// clearing enable does not stop it. Counter writes are ignored.
// Timer one vanishes when single_timer is set: it ignores items, reads zero
// and drops out of irq, but keeps its state. The single_timer register is
// written through the cfg channel, which is always ready, and must only be
// written while no item is in flight.
module dual_timer_counter_regs
    import dtc_pkg::*;
#(
    parameter int TIMER_COUNT = TimerCountDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 single_timer,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [AddrWidth-1:0] word_addr,
    input  logic [DataWidth-1:0] write_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DataWidth-1:0] read_data,
    output logic                 irq
);

    logic                 single_timer_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [1:0]           action_reg;
    logic [AddrWidth-1:0] addr_reg;
    logic [DataWidth-1:0] wdata_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [DataWidth-1:0] read_data_reg, read_data_next;
    logic                 irq_reg,       irq_next;

    logic                 stage_go;
    logic                 is_tick, is_read, is_write;

    logic [DataWidth-1:0] timer_rdata [TIMER_COUNT];
    logic [DataWidth-1:0] sel_rdata   [TIMER_COUNT];
    logic                 timer_irq   [TIMER_COUNT];

    // The item in the input register moves on when the output register is
    // free or is being emptied this cycle.
    assign stage_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || stage_go;
    assign cfg_ready = 1'b1;

    assign is_tick  = (action_reg == ACT_TICK);
    assign is_read  = (action_reg == ACT_READ);
    assign is_write = (action_reg == ACT_WRITE);

    genvar t;
    generate
        for (t = 0; t < TIMER_COUNT; t++)
        begin : g_timer
            logic     present;
            logic     hit;
            dtc_cmd_t cmd;

            if (t == 1)
            begin : g_opt
                assign present = !single_timer_reg;
            end
            else
            begin : g_fixed
                assign present = 1'b1;
            end

            assign hit         = present && (addr_reg[AddrWidth-1] == 1'(t));
            assign cmd.tick    = stage_go && is_tick && present;
            assign cmd.write   = stage_go && is_write && hit;
            assign cmd.reg_sel = addr_reg[1:0];
            assign cmd.wdata   = wdata_reg;

            dtc_timer u_timer (
                .clk      (clk),
                .rst_n    (rst_n),
                .present  (present),
                .cmd      (cmd),
                .rdata    (timer_rdata[t]),
                .irq_next (timer_irq[t])
            );

            assign sel_rdata[t] = hit ? timer_rdata[t] : '0;
        end
    endgenerate

    // Reads of an absent timer fall through as zero.
    always_comb
    begin
        read_data_next = '0;
        irq_next       = 1'b0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            read_data_next = read_data_next | sel_rdata[i];
            irq_next       = irq_next | timer_irq[i];
        end
        if (!is_read)
        begin
            read_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_timer_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                single_timer_reg <= single_timer;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (stage_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            addr_reg   <= word_addr;
            wdata_reg  <= write_data;
        end
        if (stage_go)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq       = irq_reg;

    // Only a read can put a nonzero word on read_data.
    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && !is_read |=> read_data == '0)
        else $error("read_data nonzero after a non-read item");

    // A result that waits untaken must block the processing stage.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !stage_go)
        else $error("output register overwritten while stalled");

    // The input side stalls only when both registers are full and blocked.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("in_ready low without a full, stalled pipe");

endmodule
